@@ src/isr_pkg.sv @@
// Shared types and defaults for the integer square root core.
// Used by isr_ctrl, isr_dp and integer_square_root_core; depends on nothing.
package isr_pkg;

  // Default radicand width and the fixed width of the root port
  localparam int DEF_INPUT_WIDTH = 64;
  localparam int ROOT_WIDTH      = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture radicand, clear root, set trial bit to top pair
    logic step;  // run one bit-pair iteration
  } isr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;  // trial bit sits at bit 0: current step is the final one
  } isr_status_t;

endpackage

@@ src/isr_dp.sv @@
// Datapath of the integer square root core: remainder, partial root and trial bit.
// Depends on isr_pkg for the command and status structs.
module isr_dp #(
  parameter int INPUT_WIDTH = isr_pkg::DEF_INPUT_WIDTH
) (
  input  logic                     clk,
  input  logic [INPUT_WIDTH-1:0]   radicand,
  input  isr_pkg::isr_cmd_t        cmd,
  output isr_pkg::isr_status_t     status,
  output logic [INPUT_WIDTH-1:0]   root_value
);

  // Exponent of the highest power of four that fits in the radicand width
  localparam int PAIRS   = (INPUT_WIDTH + 1) / 2;
  localparam int TOP_EXP = 2 * (PAIRS - 1);
  localparam logic [INPUT_WIDTH-1:0] BIT_INIT =
    {{(INPUT_WIDTH-1){1'b0}}, 1'b1} << TOP_EXP;

  logic [INPUT_WIDTH-1:0] rem;
  logic [INPUT_WIDTH-1:0] root;
  logic [INPUT_WIDTH-1:0] trial_bit;
  logic [INPUT_WIDTH:0]   trial;
  logic                   fits;

  // Form the trial subtrahend and compare against the remainder
  assign trial = {1'b0, root} + {1'b0, trial_bit};
  assign fits  = ({1'b0, rem} >= trial);

  // Load the operand, or advance one bit pair
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem       <= radicand;
      root      <= '0;
      trial_bit <= BIT_INIT;
    end else if (cmd.step) begin
      if (fits) begin
        rem  <= rem - trial[INPUT_WIDTH-1:0];
        root <= (root >> 1) + trial_bit;
      end else begin
        root <= root >> 1;
      end
      trial_bit <= trial_bit >> 2;
    end
  end

  assign status.last = trial_bit[0];
  assign root_value  = root;

endmodule

@@ src/isr_ctrl.sv @@
// Controller of the integer square root core: accepts a beat, sequences steps,
// raises the result strobe. Depends on isr_pkg for the command and status structs.
module isr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  isr_pkg::isr_status_t  status,
  output isr_pkg::isr_cmd_t     cmd,
  output logic                  busy,
  output logic                  done
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic done_next;
  logic accept;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // Drive datapath commands
  assign cmd.load = accept;
  assign cmd.step = (state == ST_RUN);

  // Next state: run until the final bit pair, then strobe the result
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.last) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // The strobe only shows once the engine is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // The final step always yields a strobe on the next cycle
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && status.last) |=> done)
    else $error("final step without result strobe");

  // Every strobe follows a final step
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_RUN && status.last))
    else $error("result strobe without final step");

  // An accepted beat makes the engine busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted beat did not start the engine");

endmodule

@@ src/integer_square_root_core.sv @@
// Top level of the integer square root core: floor(sqrt(radicand)).
// Depends on isr_pkg, isr_ctrl and isr_dp.
//
//   channel   signals                 direction  handshake
//   request   start, busy, radicand   in         beat taken when start && !busy
//   result    done, root              out        beat lasts one cycle while done
//
// One beat is the load edge, then one bit-pair iteration per cycle in the shared
// subtract-and-compare step of the datapath. done and root appear in the cycle
// after the last step; busy is already low then, so a new beat may start in that
// cycle. rst clears the controller; an item in flight is dropped. The receiver
// cannot stall: root holds only for the strobe cycle's worth of guarantees.
module integer_square_root_core #(
  parameter int INPUT_WIDTH = isr_pkg::DEF_INPUT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [INPUT_WIDTH-1:0]          radicand,
  output logic                            busy,
  output logic                            done,
  output logic [isr_pkg::ROOT_WIDTH-1:0]  root
);

  isr_pkg::isr_cmd_t      cmd;
  isr_pkg::isr_status_t   status;
  logic [INPUT_WIDTH-1:0] root_value;

  isr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  isr_dp #(
    .INPUT_WIDTH (INPUT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .radicand   (radicand),
    .cmd        (cmd),
    .status     (status),
    .root_value (root_value)
  );

  // Fit the root to the result port
  assign root = isr_pkg::ROOT_WIDTH'(root_value);

endmodule
